### rtl/obm_pkg.sv
// Package for the oscillator bank mixer: sequencer states, request, wave and
// status codes, and the fixed-point constants shared by the block.
// No dependencies.
`default_nettype none
package obm_pkg;

    // Request codes carried by req_type.
    localparam logic [2:0] REQ_TICK     = 3'd0;
    localparam logic [2:0] REQ_ADD      = 3'd1;
    localparam logic [2:0] REQ_REMOVE   = 3'd2;
    localparam logic [2:0] REQ_CLEAR    = 3'd3;
    localparam logic [2:0] REQ_PLAY     = 3'd4;
    localparam logic [2:0] REQ_STOP     = 3'd5;
    localparam logic [2:0] REQ_PAUSE    = 3'd6;
    // The one spare code; it leaves everything as it is.
    localparam logic [2:0] REQ_RESERVED = 3'd7;

    // Wave codes; any other code plays as silence.
    localparam logic [2:0] WAVE_SINE     = 3'd0;
    localparam logic [2:0] WAVE_SQUARE   = 3'd1;
    localparam logic [2:0] WAVE_SAW      = 3'd2;
    localparam logic [2:0] WAVE_TRIANGLE = 3'd3;
    localparam logic [2:0] WAVE_SILENT   = 3'd4;
    localparam logic [2:0] WAVE_RESERVED = 3'd7;

    // Status codes.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_BAD_INDEX = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MASTER_VOLUME = 2'd0;
    localparam logic [1:0] CFG_ATTACK_LENGTH = 2'd1;

    localparam logic [16:0] MASTER_VOLUME_RESET = 17'd49152;
    localparam logic [15:0] ATTACK_LENGTH_RESET = 16'd441;

    // Wave values are signed with 1.0 = 32768, held in 18 bits.
    localparam int VAL_W = 18;
    // Ramped wave times gain stays below 2^31 in magnitude.
    localparam int PROD_W = 33;

    // Two pi in Q28, used to build the sine table.
    localparam longint unsigned TWO_PI_Q28 = 64'd1686629713;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_PH,
        S_VAL,
        S_RAMP,
        S_RDIV,
        S_MUL,
        S_ACC,
        S_CDIV,
        S_CWAIT,
        S_VOL,
        S_SAT,
        S_SHR,
        S_SHW,
        S_DONE
    } state_t;

endpackage
`default_nettype wire

### rtl/obm_div.sv
// Unsigned restoring divider for the oscillator bank mixer, one quotient bit
// per cycle, with a 16-bit divisor. No dependencies.
`default_nettype none
module obm_div #(
    parameter int DIVIDEND_W = 37
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [15:0]           divisor,
    output logic      [DIVIDEND_W-1:0] quotient,
    output logic                       busy,
    output logic                       done
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [CNT_W-1:0]      cnt_reg;
    logic                  done_reg;
    logic [15:0]           rem_reg;
    logic [15:0]           rem_next;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVIDEND_W-1:0] quo_next;
    logic [15:0]           divisor_reg;
    logic [16:0]           trial;
    logic                  fits;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[DIVIDEND_W-1]};
        fits     = trial >= {1'b0, divisor_reg};
        rem_next = fits ? 16'(trial - {1'b0, divisor_reg}) : trial[15:0];
        quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(DIVIDEND_W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= '0;
            quo_reg     <= dividend;
            divisor_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient = quo_reg;
    assign busy     = cnt_reg != '0;
    assign done     = done_reg;

endmodule
`default_nettype wire

### rtl/oscillator_bank_mixer.sv
// Oscillator bank mixer top level: oscillator table memory, sine ROM,
// request sequencer and mixing datapath. Depends on obm_pkg and obm_div.
//
//  Channel   Handshake               Payload
//  --------  ----------------------  ------------------------------------------
//  request   start & !busy           req_type, phase_step, amplitude, wave,
//                                    osc_index
//  result    done (one cycle)        sample, clipped, status, osc_count
//  config    cfg_we                  cfg_index, cfg_data
//
// Every request transaction gives exactly one result transaction. Requests
// other than a tick or a remove that moves entries, and silent ticks, go
// straight to the result. A playing tick walks the oscillator table one
// entry at a time: it reads the entry, writes back the advanced phase,
// shapes the wave, ramps it by the attack divide while the ramp runs,
// scales it by the gain and sums it; then it divides the sum by the count,
// applies the master volume and saturates. A remove moves each later entry
// down one place. The reset is asynchronous and needs no clearing pass; busy
// stays high until the result has been shown; the receiver cannot stall it.
`default_nettype none
module oscillator_bank_mixer #(
    parameter int MAX_OSCILLATORS  = 16,
    parameter int PHASE_BITS       = 24,
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int SAMPLE_BITS      = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [2:0]                    req_type,
    input  wire logic [PHASE_BITS-1:0]         phase_step,
    input  wire logic [15:0]                   amplitude,
    input  wire logic [2:0]                    wave,
    input  wire logic [3:0]                    osc_index,
    output logic                               done,
    output logic signed [SAMPLE_BITS-1:0]      sample,
    output logic                               clipped,
    output logic [1:0]                         status,
    output logic [4:0]                         osc_count,
    input  wire logic                          cfg_we,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [16:0]                   cfg_data
);

    localparam int VAL_W  = obm_pkg::VAL_W;
    localparam int PROD_W = obm_pkg::PROD_W;
    localparam int CNT_W  = $clog2(MAX_OSCILLATORS + 1);
    localparam int IDX_W  = (MAX_OSCILLATORS > 1) ? $clog2(MAX_OSCILLATORS) : 1;
    localparam int ROM_W  = $clog2(SINE_TABLE_DEPTH);
    localparam int SUM_W  = PROD_W + $clog2(MAX_OSCILLATORS);
    localparam int DIV_W  = SUM_W;
    localparam int VOL_W  = 49;
    localparam int SHIFT  = 47 - SAMPLE_BITS;
    localparam logic [VOL_W-1:0] LIM = VOL_W'(1) << (SAMPLE_BITS - 1);
    localparam logic [PHASE_BITS-1:0] HALF = PHASE_BITS'(1) << (PHASE_BITS - 1);
    localparam longint unsigned TAYLOR_DIV [8] = '{6, 20, 42, 72, 110, 156, 210, 272};

    typedef struct packed {
        logic [PHASE_BITS-1:0] phase;
        logic [PHASE_BITS-1:0] step;
        logic [15:0]           gain;
        logic [2:0]            wave;
    } osc_entry_t;

    // Sine table entry k: round(32768 * sin(2 pi k / depth)) by a Q28 series.
    function automatic logic signed [VAL_W-1:0] sine_entry(input int unsigned k);
        logic             neg;
        longint unsigned  m;
        longint unsigned  x;
        longint unsigned  x2;
        longint unsigned  term;
        longint           acc;
        longint           v;
        neg = 1'b0;
        m   = k;
        if (2 * m > SINE_TABLE_DEPTH)
        begin
            m   = SINE_TABLE_DEPTH - m;
            neg = 1'b1;
        end
        x    = obm_pkg::TWO_PI_Q28 * m / SINE_TABLE_DEPTH;
        x2   = (x * x) >> 28;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 8; n++)
        begin
            term = ((term * x2) >> 28) / TAYLOR_DIV[n-1];
            if ((n % 2) == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        v = (acc + 4096) >>> 13;
        if (v > 32768)
            v = 32768;
        return neg ? VAL_W'(-v) : VAL_W'(v);
    endfunction

    // Storage: one oscillator table and one sine ROM, both read through a
    // registered port.
    osc_entry_t                 osc_mem [MAX_OSCILLATORS];
    logic signed [VAL_W-1:0]    sine_rom [SINE_TABLE_DEPTH];

    for (genvar k = 0; k < SINE_TABLE_DEPTH; k++)
    begin : g_sine
        assign sine_rom[k] = sine_entry(k);
    end

    obm_pkg::state_t state_reg;
    obm_pkg::state_t state_next;

    logic [CNT_W-1:0]  count_reg;
    logic              playing_reg;
    logic [31:0]       sc_reg;
    logic [CNT_W-1:0]  i_reg;
    logic [CNT_W-1:0]  j_reg;
    logic [16:0]       master_volume_reg;
    logic [15:0]       attack_length_reg;

    osc_entry_t                  mem_q_reg;
    logic signed [VAL_W-1:0]     sine_q_reg;
    logic [ROM_W-1:0]            rom_idx;
    logic [PHASE_BITS-1:0]       p_reg;
    logic [2:0]                  w_reg;
    logic [15:0]                 gain_reg;
    logic signed [VAL_W-1:0]     v_reg;
    logic signed [VAL_W-1:0]     wave_val;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [SUM_W-1:0]     sum_reg;
    logic [31:0]                 avg_mag_reg;
    logic                        neg_reg;
    logic [VOL_W-1:0]            vol_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic                        clipped_reg;
    logic [1:0]                  status_reg;

    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    osc_entry_t            mem_wdata;
    logic [IDX_W-1:0]      mem_raddr;
    logic                  div_start;
    logic [DIV_W-1:0]      div_dividend;
    logic [15:0]           div_divisor;
    logic [DIV_W-1:0]      div_quotient;
    logic                  div_busy;
    logic                  div_done;

    logic                  accept;
    logic                  tick_live;
    logic                  ramp_on;
    logic                  idx_ok;
    logic                  last_entry;
    logic                  shift_more;
    logic                  first_shift;
    logic [15:0]           v_mag;
    logic [SUM_W-1:0]      sum_mag;
    logic [VOL_W-1:0]      vol_mag;
    logic signed [VAL_W-1:0] ramp_val;
    logic [PHASE_BITS-1:0] saw_ph;
    logic [PHASE_BITS+15:0] saw_wide;
    logic signed [VAL_W-1:0] saw;
    logic signed [VAL_W-1:0] saw_abs;
    logic [PHASE_BITS+ROM_W:0] rom_prod;

    assign accept      = start && (state_reg == obm_pkg::S_IDLE);
    assign tick_live   = playing_reg && (count_reg != '0);
    assign ramp_on     = sc_reg < {16'd0, attack_length_reg};
    assign idx_ok      = {4'd0, osc_index} < 8'(count_reg);
    assign last_entry  = ({1'b0, i_reg} + 1'b1) == {1'b0, count_reg};
    assign first_shift = ({5'd0, osc_index} + 9'd1) < 9'(count_reg);
    assign shift_more  = ({1'b0, j_reg} + 2'd2) < {1'b0, count_reg};

    // Wave shaping from the latched phase; the sine comes from the ROM.
    always_comb
    begin
        saw_ph   = p_reg + HALF;
        saw_wide = {saw_ph, 16'd0} >> PHASE_BITS;
        saw      = $signed({2'b00, saw_wide[15:0]}) - VAL_W'(32768);
        saw_abs  = (saw < 0) ? -saw : saw;
        case (w_reg)
            obm_pkg::WAVE_SINE:     wave_val = sine_q_reg;
            obm_pkg::WAVE_SQUARE:   wave_val = p_reg[PHASE_BITS-1] ? -VAL_W'(32768)
                                                                   : VAL_W'(32768);
            obm_pkg::WAVE_SAW:      wave_val = saw;
            obm_pkg::WAVE_TRIANGLE: wave_val = (saw_abs <<< 1) - VAL_W'(32768);
            default:                wave_val = '0;
        endcase
    end

    always_comb
    begin
        rom_prod = (PHASE_BITS + ROM_W + 1)'(mem_q_reg.phase)
                   * (PHASE_BITS + ROM_W + 1)'(SINE_TABLE_DEPTH);
        rom_idx  = ROM_W'(rom_prod >> PHASE_BITS);
        v_mag    = (v_reg < 0) ? 16'(-v_reg) : 16'(v_reg);
        sum_mag  = (sum_reg < 0) ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        vol_mag  = vol_reg >> SHIFT;
        ramp_val = neg_reg ? -$signed({2'b00, div_quotient[15:0]})
                           :  $signed({2'b00, div_quotient[15:0]});
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            obm_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if ((req_type == obm_pkg::REQ_TICK) && tick_live)
                        state_next = obm_pkg::S_RD;
                    else if ((req_type == obm_pkg::REQ_REMOVE) && idx_ok && first_shift)
                        state_next = obm_pkg::S_SHR;
                    else
                        state_next = obm_pkg::S_DONE;
                end
            end
            obm_pkg::S_RD:    state_next = obm_pkg::S_PH;
            obm_pkg::S_PH:    state_next = obm_pkg::S_VAL;
            obm_pkg::S_VAL:   state_next = obm_pkg::S_RAMP;
            obm_pkg::S_RAMP:  state_next = ramp_on ? obm_pkg::S_RDIV : obm_pkg::S_MUL;
            obm_pkg::S_RDIV:  state_next = div_done ? obm_pkg::S_MUL : obm_pkg::S_RDIV;
            obm_pkg::S_MUL:   state_next = obm_pkg::S_ACC;
            obm_pkg::S_ACC:   state_next = last_entry ? obm_pkg::S_CDIV : obm_pkg::S_RD;
            obm_pkg::S_CDIV:  state_next = obm_pkg::S_CWAIT;
            obm_pkg::S_CWAIT: state_next = div_done ? obm_pkg::S_VOL : obm_pkg::S_CWAIT;
            obm_pkg::S_VOL:   state_next = obm_pkg::S_SAT;
            obm_pkg::S_SAT:   state_next = obm_pkg::S_DONE;
            obm_pkg::S_SHR:   state_next = obm_pkg::S_SHW;
            obm_pkg::S_SHW:   state_next = shift_more ? obm_pkg::S_SHR : obm_pkg::S_DONE;
            obm_pkg::S_DONE:  state_next = obm_pkg::S_IDLE;
            default:          state_next = obm_pkg::S_IDLE;
        endcase
    end

    // Memory port, divider and handshake controls.
    always_comb
    begin
        mem_we       = 1'b0;
        mem_waddr    = i_reg[IDX_W-1:0];
        mem_wdata    = mem_q_reg;
        mem_raddr    = i_reg[IDX_W-1:0];
        div_start    = 1'b0;
        div_dividend = DIV_W'(sum_mag);
        div_divisor  = 16'(count_reg);
        busy         = state_reg != obm_pkg::S_IDLE;
        done         = state_reg == obm_pkg::S_DONE;
        case (state_reg)
            obm_pkg::S_IDLE:
            begin
                if (accept && (req_type == obm_pkg::REQ_ADD) &&
                    (count_reg < CNT_W'(MAX_OSCILLATORS)))
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = count_reg[IDX_W-1:0];
                    mem_wdata.phase = '0;
                    mem_wdata.step  = phase_step;
                    mem_wdata.gain  = amplitude;
                    mem_wdata.wave  = wave;
                end
            end
            obm_pkg::S_PH:
            begin
                mem_we          = 1'b1;
                mem_wdata.phase = mem_q_reg.phase + mem_q_reg.step;
            end
            obm_pkg::S_RAMP:
            begin
                div_start    = ramp_on;
                div_dividend = DIV_W'(32'(v_mag) * 32'(sc_reg[15:0]));
                div_divisor  = attack_length_reg;
            end
            obm_pkg::S_CDIV:
            begin
                div_start = 1'b1;
            end
            obm_pkg::S_SHR:
            begin
                mem_raddr = IDX_W'(j_reg + 1'b1);
            end
            obm_pkg::S_SHW:
            begin
                mem_we    = 1'b1;
                mem_waddr = j_reg[IDX_W-1:0];
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    obm_div #(
        .DIVIDEND_W (DIV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .busy     (div_busy),
        .done     (div_done)
    );

    always_ff @(posedge clk)
    begin
        if (mem_we)
            osc_mem[mem_waddr] <= mem_wdata;
        mem_q_reg  <= osc_mem[mem_raddr];
        sine_q_reg <= sine_rom[rom_idx];
    end

    // Control state and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= obm_pkg::S_IDLE;
            count_reg         <= '0;
            playing_reg       <= 1'b0;
            sc_reg            <= '0;
            i_reg             <= '0;
            j_reg             <= '0;
            master_volume_reg <= obm_pkg::MASTER_VOLUME_RESET;
            attack_length_reg <= obm_pkg::ATTACK_LENGTH_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                if (cfg_index == obm_pkg::CFG_MASTER_VOLUME)
                    master_volume_reg <= cfg_data;
                else if (cfg_index == obm_pkg::CFG_ATTACK_LENGTH)
                    attack_length_reg <= cfg_data[15:0];
            end
            case (state_reg)
                obm_pkg::S_IDLE:
                begin
                    i_reg <= '0;
                    j_reg <= CNT_W'(osc_index);
                    if (accept)
                    begin
                        case (req_type)
                            obm_pkg::REQ_ADD:
                                if (count_reg < CNT_W'(MAX_OSCILLATORS))
                                    count_reg <= count_reg + 1'b1;
                            obm_pkg::REQ_REMOVE:
                                if (idx_ok && !first_shift)
                                    count_reg <= count_reg - 1'b1;
                            obm_pkg::REQ_CLEAR: count_reg <= '0;
                            obm_pkg::REQ_PLAY:  playing_reg <= 1'b1;
                            obm_pkg::REQ_STOP:
                            begin
                                playing_reg <= 1'b0;
                                sc_reg      <= '0;
                            end
                            obm_pkg::REQ_PAUSE: playing_reg <= !playing_reg;
                            default:            playing_reg <= playing_reg;
                        endcase
                    end
                end
                obm_pkg::S_ACC: i_reg <= i_reg + 1'b1;
                obm_pkg::S_SAT: sc_reg <= sc_reg + 1'b1;
                obm_pkg::S_SHW:
                begin
                    j_reg <= j_reg + 1'b1;
                    if (!shift_more)
                        count_reg <= count_reg - 1'b1;
                end
                default: i_reg <= i_reg;
            endcase
        end
    end

    // Mixing datapath and result registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            obm_pkg::S_IDLE:
            begin
                sum_reg     <= '0;
                sample_reg  <= '0;
                clipped_reg <= 1'b0;
                status_reg  <= obm_pkg::STATUS_OK;
                if (accept && (req_type == obm_pkg::REQ_ADD) &&
                    (count_reg >= CNT_W'(MAX_OSCILLATORS)))
                    status_reg <= obm_pkg::STATUS_FULL;
                if (accept && (req_type == obm_pkg::REQ_REMOVE) && !idx_ok)
                    status_reg <= obm_pkg::STATUS_BAD_INDEX;
            end
            obm_pkg::S_PH:
            begin
                p_reg    <= mem_q_reg.phase;
                w_reg    <= mem_q_reg.wave;
                gain_reg <= mem_q_reg.gain;
            end
            obm_pkg::S_VAL:  v_reg <= wave_val;
            obm_pkg::S_RAMP: neg_reg <= v_reg < 0;
            obm_pkg::S_RDIV:
                if (div_done)
                    v_reg <= ramp_val;
            obm_pkg::S_MUL:  prod_reg <= PROD_W'(v_reg * $signed({1'b0, gain_reg}));
            obm_pkg::S_ACC:  sum_reg <= sum_reg + SUM_W'(prod_reg);
            obm_pkg::S_CDIV: neg_reg <= sum_reg < 0;
            obm_pkg::S_CWAIT:
                if (div_done)
                    avg_mag_reg <= div_quotient[31:0];
            obm_pkg::S_VOL:  vol_reg <= VOL_W'(avg_mag_reg) * VOL_W'(master_volume_reg);
            obm_pkg::S_SAT:
            begin
                // Sign-magnitude keeps the truncation toward zero.
                if (neg_reg)
                begin
                    clipped_reg <= vol_mag > LIM;
                    sample_reg  <= (vol_mag > LIM) ? -$signed(SAMPLE_BITS'(LIM))
                                                   : -$signed(SAMPLE_BITS'(vol_mag));
                end
                else
                begin
                    clipped_reg <= vol_mag >= LIM;
                    sample_reg  <= (vol_mag >= LIM) ? $signed(SAMPLE_BITS'(LIM - 1'b1))
                                                    : $signed(SAMPLE_BITS'(vol_mag));
                end
            end
            default: sum_reg <= sum_reg;
        endcase
    end

    assign sample    = sample_reg;
    assign clipped   = clipped_reg;
    assign status    = status_reg;
    assign osc_count = 5'(count_reg);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_OSCILLATORS))
        else $error("oscillator count above table size");
    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");
    a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block still busy after a result");
    a_phase_wb: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == obm_pkg::S_PH) |-> (mem_waddr == $past(mem_raddr)))
        else $error("phase written back to the wrong entry");
`endif

endmodule
`default_nettype wire
